// ===== rtl/core/ifpd_pkg.sv =====
// Package for the interrupt flag and priority dispatch core.
// Holds action and read-select codes, dispatch constants and the result type.
// No dependencies.
package ifpd_pkg;

    localparam int ACTION_W = 3;
    localparam int SEL_W    = 2;
    localparam int DATA_W   = 8;
    localparam int VEC_W    = 7;
    localparam int DELAY_W  = 2;
    localparam int SRC_N    = 5;
    localparam int SRC_IDX_W = 3;

    // actions
    localparam logic [ACTION_W-1:0] ACT_RAISE     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CHECK     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ENABLE    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DISABLE   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WR_FLAGS  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_WR_ENABLE = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd6;

    // read selectors
    localparam logic [SEL_W-1:0] SEL_FLAGS  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_ENABLE = 2'd1;
    localparam logic [SEL_W-1:0] SEL_MASTER = 2'd2;

    localparam logic [VEC_W-1:0]   VECTOR_BASE = 7'h40;
    localparam logic [VEC_W-1:0]   VECTOR_STEP = 7'h08;
    localparam logic [DELAY_W-1:0] DELAY_START = 2'd2;

    typedef struct packed {
        logic              fired;
        logic [VEC_W-1:0]  vector;
        logic              wake;
        logic [DATA_W-1:0] read_data;
    } result_t;

endpackage

// ===== rtl/core/ifpd_prio_enc.sv =====
// Five-source priority encoder: lowest-numbered set bit wins.
// Depends on ifpd_pkg.
module ifpd_prio_enc (
    input  logic [ifpd_pkg::SRC_N-1:0]     live,
    output logic                           hit,
    output logic [ifpd_pkg::SRC_IDX_W-1:0] idx
);
    import ifpd_pkg::*;

    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = SRC_N - 1; i >= 0; i--) begin
            if (live[i]) begin
                hit = 1'b1;
                idx = SRC_IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/core/ifpd_ctrl.sv =====
// Interrupt state registers (flags, enables, master enable, enable delay)
// and the per-request action logic. Depends on ifpd_pkg and ifpd_prio_enc.
module ifpd_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [ifpd_pkg::ACTION_W-1:0] action,
    input  logic [ifpd_pkg::DATA_W-1:0]   data,
    input  logic [ifpd_pkg::SEL_W-1:0]    read_select,
    output ifpd_pkg::result_t             result
);
    import ifpd_pkg::*;

    logic [DATA_W-1:0]  flags_reg, flags_next;
    logic [DATA_W-1:0]  enable_reg, enable_next;
    logic               master_reg, master_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;

    logic [DATA_W-1:0]    flags_raised;
    logic [DATA_W-1:0]    live;
    logic                 master_eff;
    logic                 hit;
    logic [SRC_IDX_W-1:0] idx;

    assign flags_raised = (action == ACT_RAISE) ? (flags_reg | data) : flags_reg;
    assign master_eff   = master_reg | (delay_reg == 2'd1);
    assign live         = flags_raised & enable_reg;

    ifpd_prio_enc u_prio (
        .live (live[SRC_N-1:0]),
        .hit  (hit),
        .idx  (idx)
    );

    always_comb begin
        flags_next  = flags_reg;
        enable_next = enable_reg;
        master_next = master_reg;
        delay_next  = delay_reg;
        result      = '0;
        case (action)
            ACT_RAISE, ACT_CHECK: begin
                flags_next = flags_raised;
                if (delay_reg >= 2'd2) begin
                    // still counting down, nothing else this boundary
                    delay_next = delay_reg - 2'd1;
                end else begin
                    delay_next  = '0;
                    master_next = master_eff;
                    if (!master_eff) begin
                        result.wake = |live;
                    end else if (hit) begin
                        master_next       = 1'b0;
                        flags_next[idx]   = 1'b0;
                        result.fired      = 1'b1;
                        result.vector     = VECTOR_BASE + VEC_W'(idx) * VECTOR_STEP;
                    end
                end
            end
            ACT_ENABLE:    delay_next  = DELAY_START;
            ACT_DISABLE:   master_next = 1'b0;
            ACT_WR_FLAGS:  flags_next  = data;
            ACT_WR_ENABLE: enable_next = data;
            ACT_READ: begin
                case (read_select)
                    SEL_FLAGS:  result.read_data = flags_reg;
                    SEL_ENABLE: result.read_data = enable_reg;
                    SEL_MASTER: result.read_data =
                        DATA_W'(master_reg & (delay_reg == '0));
                    default:    result.read_data = '0;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg  <= '0;
            enable_reg <= '0;
            master_reg <= 1'b0;
            delay_reg  <= '0;
        end else if (step) begin
            flags_reg  <= flags_next;
            enable_reg <= enable_next;
            master_reg <= master_next;
            delay_reg  <= delay_next;
        end
    end

endmodule

// ===== rtl/core/interrupt_flag_priority_dispatch_core.sv =====
// Top level of the interrupt flag and priority dispatch core.
// Depends on ifpd_pkg and ifpd_ctrl.
//
// Usage:
//   Input channel (s_valid/s_ready): one request per handshake carrying
//   s_action, s_data and s_read_select. Result channel (m_valid/m_ready):
//   one result per request with m_fired, m_vector, m_wake, m_read_data,
//   delivered in request order.
//   Flow: an accepted request is registered in the input register, processed
//   against the interrupt state when the result stage can advance, and its
//   result is registered in the result register that drives the m_ ports.
//   Throughput: one request per cycle unless the result channel stalls; the
//   flag/enable/master/delay registers that every request reads and writes are updated as it is processed.
//   Stall: when m_ready is low with a result waiting, the processing stage
//   holds and s_ready drops once the input register is also occupied; no
//   request is lost or repeated.
//   Reset (aresetn low, synchronous): all state and the valid bits of both
//   pipeline stages are cleared; flags, enables, master enable and delay read as zero.
module interrupt_flag_priority_dispatch_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ifpd_pkg::ACTION_W-1:0] s_action,
    input  logic [ifpd_pkg::DATA_W-1:0]   s_data,
    input  logic [ifpd_pkg::SEL_W-1:0]    s_read_select,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_fired,
    output logic [ifpd_pkg::VEC_W-1:0]    m_vector,
    output logic                          m_wake,
    output logic [ifpd_pkg::DATA_W-1:0]   m_read_data
);
    import ifpd_pkg::*;

    logic                in_valid_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [SEL_W-1:0]    sel_reg;

    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic advance;
    logic step;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    ifpd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .action      (action_reg),
        .data        (data_reg),
        .read_select (sel_reg),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            data_reg   <= s_data;
            sel_reg    <= s_read_select;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_fired     = result_reg.fired;
    assign m_vector    = result_reg.vector;
    assign m_wake      = result_reg.wake;
    assign m_read_data = result_reg.read_data;

endmodule

// ===== rtl/core/ifpd_checker.sv =====
// Port-level checker for the interrupt flag and priority dispatch core,
// bound to the top level. Depends on ifpd_pkg.
module ifpd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_fired,
    input logic [ifpd_pkg::VEC_W-1:0]  m_vector,
    input logic                        m_wake,
    input logic [ifpd_pkg::DATA_W-1:0] m_read_data
);
    import ifpd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fired) && $stable(m_vector)
            && $stable(m_wake) && $stable(m_read_data))
        else $error("result changed while stalled");

    a_vec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fired |-> m_vector == '0)
        else $error("vector set without dispatch");

    a_vec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fired |-> m_vector == 7'h40 || m_vector == 7'h48
            || m_vector == 7'h50 || m_vector == 7'h58 || m_vector == 7'h60)
        else $error("dispatch vector out of range");

    // a boundary check never also returns read data, and fire excludes wake
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_fired || m_wake) |-> m_read_data == '0 && !(m_fired && m_wake))
        else $error("mixed result kinds");

endmodule

bind interrupt_flag_priority_dispatch_core ifpd_checker u_ifpd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_fired     (m_fired),
    .m_vector    (m_vector),
    .m_wake      (m_wake),
    .m_read_data (m_read_data)
);

// ===== tb/sv/interrupt_flag_priority_dispatch_core_tb.sv =====
// Self-checking testbench for interrupt_flag_priority_dispatch_core.
// Depends on ifpd_pkg and the core RTL. A scoreboard class keeps its own copy of the
// flag/enable/master/delay state and checks each result in request order.
`timescale 1ns / 100ps

module interrupt_flag_priority_dispatch_core_tb;

    import ifpd_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam logic [SEL_W-1:0]    SEL_NONE   = 2'd3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_PRINTED   = 40;
    localparam int RANDOM_ITEMS  = 1400;

    class dispatch_scoreboard;
        logic [DATA_W-1:0]  req_flags;
        logic [DATA_W-1:0]  irq_enables;
        logic               ime;
        logic [DELAY_W-1:0] ei_delay;
        result_t            owed_irq_results[$];
        int                 mismatches;

        function new();
            req_flags   = '0;
            irq_enables = '0;
            ime         = 1'b0;
            ei_delay    = '0;
            mismatches  = 0;
        endfunction

        // Instruction boundary: delay countdown, then wake or single dispatch.
        function void instr_boundary(inout result_t r);
            logic [DATA_W-1:0] live;
            logic              done;
            if (ei_delay >= 2) begin
                ei_delay = ei_delay - 1'b1;
                return;
            end
            if (ei_delay == 1) begin
                ime      = 1'b1;
                ei_delay = '0;
            end
            live = req_flags & irq_enables;
            if (!ime) begin
                r.wake = (live != '0);
                return;
            end
            done = 1'b0;
            for (int i = 0; i < SRC_N; i++) begin
                if (!done && live[i]) begin
                    done         = 1'b1;
                    ime          = 1'b0;
                    req_flags[i] = 1'b0;
                    r.fired      = 1'b1;
                    r.vector     = VECTOR_BASE + VEC_W'(VECTOR_STEP * i);
                end
            end
        endfunction

        function void note_request(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] dat,
                                   logic [SEL_W-1:0] sel);
            result_t r;
            r = '0;
            case (act)
                ACT_RAISE: begin
                    req_flags = req_flags | dat;
                    instr_boundary(r);
                end
                ACT_CHECK:     instr_boundary(r);
                ACT_ENABLE:    ei_delay = DELAY_START;
                ACT_DISABLE:   ime = 1'b0;
                ACT_WR_FLAGS:  req_flags = dat;
                ACT_WR_ENABLE: irq_enables = dat;
                ACT_READ: begin
                    case (sel)
                        SEL_FLAGS:  r.read_data = req_flags;
                        SEL_ENABLE: r.read_data = irq_enables;
                        SEL_MASTER: r.read_data = DATA_W'(ime && (ei_delay == '0));
                        default:    r.read_data = '0;
                    endcase
                end
                default: ;
            endcase
            owed_irq_results.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (mismatches < MAX_PRINTED)
                $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (owed_irq_results.size() == 0) begin
                report("unexpected result", 32'(got), 0);
                return;
            end
            want = owed_irq_results.pop_front();
            if (got.fired !== want.fired)
                report("fired", 32'(got.fired), 32'(want.fired));
            if (got.vector !== want.vector)
                report("vector", 32'(got.vector), 32'(want.vector));
            if (got.wake !== want.wake)
                report("wake", 32'(got.wake), 32'(want.wake));
            if (got.read_data !== want.read_data)
                report("read_data", 32'(got.read_data), 32'(want.read_data));
        endtask

        task check_drained();
            if (owed_irq_results.size() != 0)
                report("results still owed", owed_irq_results.size(), 0);
        endtask
    endclass

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action      = '0;
    logic [DATA_W-1:0]   s_data        = '0;
    logic [SEL_W-1:0]    s_read_select = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_fired;
    logic [VEC_W-1:0]    m_vector;
    logic                m_wake;
    logic [DATA_W-1:0]   m_read_data;

    int src_idle_pct   = 19;
    int sink_stall_pct = 54;
    int cycle_count    = 0;

    dispatch_scoreboard sb;

    interrupt_flag_priority_dispatch_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_data        (s_data),
        .s_read_select (s_read_select),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fired       (m_fired),
        .m_vector      (m_vector),
        .m_wake        (m_wake),
        .m_read_data   (m_read_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin : monitor
        result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.fired     = m_fired;
                got.vector    = m_vector;
                got.wake      = m_wake;
                got.read_data = m_read_data;
                sb.check_result(got);
            end
            if (s_valid && s_ready)
                sb.note_request(s_action, s_data, s_read_select);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Valid stays high from one request to the next unless an idle gap is drawn.
    task automatic send_req(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] dat,
                            input logic [SEL_W-1:0] sel);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_data        <= dat;
        s_read_select <= sel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 3))
            0, 1:    return DATA_W'($urandom_range(0, 255));
            2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: return DATA_W'($urandom & $urandom);
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 22)      return ACT_RAISE;
        else if (roll < 50) return ACT_CHECK;
        else if (roll < 60) return ACT_ENABLE;
        else if (roll < 65) return ACT_DISABLE;
        else if (roll < 73) return ACT_WR_FLAGS;
        else if (roll < 83) return ACT_WR_ENABLE;
        else if (roll < 97) return ACT_READ;
        else                return ACT_UNUSED;
    endfunction

    // Mixes enable-then-boundary sequences (drawn 15 in 100 times) with single requests so dispatches actually happen.
    task automatic run_random(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 15) begin
                send_req(ACT_ENABLE, pick_data(), SEL_W'($urandom_range(0, 3)));
                send_req(ACT_CHECK, pick_data(), SEL_W'($urandom_range(0, 3)));
                send_req($urandom_range(0, 1) ? ACT_RAISE : ACT_CHECK, pick_data(),
                         SEL_W'($urandom_range(0, 3)));
                sent += 3;
            end else begin
                send_req(pick_action(), pick_data(), SEL_W'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, unused selector
        send_req(ACT_READ, 8'hFF, SEL_FLAGS);
        send_req(ACT_READ, 8'h00, SEL_ENABLE);
        send_req(ACT_READ, 8'hFF, SEL_MASTER);
        send_req(ACT_READ, 8'hFF, SEL_NONE);
        // upper request bits wake but never fire
        send_req(ACT_WR_ENABLE, 8'hFF, SEL_FLAGS);
        send_req(ACT_WR_FLAGS, 8'hE0, SEL_FLAGS);
        send_req(ACT_CHECK, 8'h00, SEL_FLAGS);
        send_req(ACT_ENABLE, 8'h00, SEL_FLAGS);
        send_req(ACT_CHECK, 8'h00, SEL_FLAGS);
        send_req(ACT_CHECK, 8'h00, SEL_FLAGS);
        send_req(ACT_READ, 8'h00, SEL_MASTER);
        // priority: bit 0 first, then wake with master off
        send_req(ACT_RAISE, 8'h1F, SEL_FLAGS);
        send_req(ACT_CHECK, 8'h00, SEL_FLAGS);
        // disable does not cancel a running delay
        send_req(ACT_ENABLE, 8'h00, SEL_FLAGS);
        send_req(ACT_CHECK, 8'h00, SEL_FLAGS);
        send_req(ACT_DISABLE, 8'h00, SEL_FLAGS);
        send_req(ACT_CHECK, 8'h00, SEL_FLAGS);
        // only bit 4 enabled
        send_req(ACT_WR_ENABLE, 8'h10, SEL_FLAGS);
        send_req(ACT_ENABLE, 8'h00, SEL_FLAGS);
        send_req(ACT_CHECK, 8'h00, SEL_FLAGS);
        send_req(ACT_RAISE, 8'h00, SEL_FLAGS);
        // master off with enable delay pending reads as off
        send_req(ACT_ENABLE, 8'h00, SEL_FLAGS);
        send_req(ACT_READ, 8'h00, SEL_MASTER);
        send_req(ACT_UNUSED, 8'hFF, SEL_NONE);
        send_req(ACT_READ, 8'h00, SEL_FLAGS);

        run_random(RANDOM_ITEMS / 3);
        src_idle_pct   = 54;
        sink_stall_pct = 19;
        run_random(RANDOM_ITEMS / 3);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        s_valid <= 1'b0;
        while (sb.owed_irq_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.check_drained();
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== interrupt_flag_priority_dispatch_core.f =====
rtl/core/ifpd_pkg.sv
rtl/core/ifpd_prio_enc.sv
rtl/core/ifpd_ctrl.sv
rtl/core/interrupt_flag_priority_dispatch_core.sv
rtl/core/ifpd_checker.sv
tb/sv/interrupt_flag_priority_dispatch_core_tb.sv
